// ===== rtl/vertex_vector_light_shader_unit_assert.svh =====
// assertion macros for the light shader unit checker
// no dependencies
`ifndef VERTEX_VECTOR_LIGHT_SHADER_UNIT_ASSERT_SVH
`define VERTEX_VECTOR_LIGHT_SHADER_UNIT_ASSERT_SVH
// implication into the next cycle, ignored during reset
`define VVLS_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error("assert failed");
// implication into the next cycle, checked during reset too
`define VVLS_ASSERT_NEXT_ALWAYS(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) else $error("assert failed");
`endif

// ===== rtl/vvls_pkg.sv =====
// shared types and constants for the light shader unit
// no dependencies
package vvls_pkg;
  localparam int LIGHT_SLOTS_DEF = 16;
  localparam int MAX_LIGHTS_RST = 5;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SHADE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [4:0]         slot_or_count;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic signed [15:0] shift_toward_light;
    logic signed [15:0] lit_gain;
    logic signed [15:0] dark_gain;
    logic [12:0]        red;
    logic [12:0]        green;
    logic [12:0]        blue;
    logic [12:0]        flag_or_alpha;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } head_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic signed [15:0] off;
    logic signed [15:0] lit;
    logic signed [15:0] dark;
    logic [12:0]        r;
    logic [12:0]        g;
    logic [12:0]        b;
    logic               amb_flag;
  } light_t;
endpackage

// ===== rtl/vvls_front.sv =====
// request acceptance and two-entry command queue
// depends on vvls_pkg
module vvls_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  vvls_pkg::cmd_t req,
  output logic          busy,
  output vvls_pkg::head_t head,
  input  logic          pop
);
  vvls_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       take;

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;
  assign take = pop && (cnt != 2'd0);
  assign head.valid = (cnt != 2'd0);
  assign head.cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (take) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(take);
    end
  end
endmodule

// ===== rtl/vvls_back.sv =====
// light table and per-light shading sequencer
// depends on vvls_pkg
module vvls_back #(
  parameter int LIGHT_SLOTS = vvls_pkg::LIGHT_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      max_lights,
  input  vvls_pkg::head_t head,
  output logic            pop,
  output logic            done,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);
  localparam int IDXW = $clog2(LIGHT_SLOTS);
  localparam int CW = $clog2(LIGHT_SLOTS + 1);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DOT  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_GAIN = 3'd4;
  localparam logic [2:0] S_COL  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  vvls_pkg::light_t mem [LIGHT_SLOTS];
  vvls_pkg::light_t rd;
  vvls_pkg::light_t wr_ent;
  vvls_pkg::cmd_t   cur;
  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      n;
  logic [CW-1:0]      n_next;
  logic signed [31:0] px, py, pz;
  logic signed [33:0] s;
  logic signed [48:0] sg;
  logic signed [41:0] sc;
  logic signed [55:0] cr, cg, cb;
  logic signed [59:0] s0 [3];
  logic signed [59:0] s1 [3];
  logic [7:0]         byte_v [3];
  logic [12:0]        amb [3];
  logic [20:0]        alpha_w;

  always_comb begin
    int t;
    t = int'(head.cmd.slot_or_count);
    if (t > LIGHT_SLOTS) t = LIGHT_SLOTS;
    if (t > int'(max_lights)) t = int'(max_lights);
    n_next = CW'(t);
  end

  assign pop = (state == S_IDLE);
  assign wr_ent.dx = head.cmd.vec_x;
  assign wr_ent.dy = head.cmd.vec_y;
  assign wr_ent.dz = head.cmd.vec_z;
  assign wr_ent.off = head.cmd.shift_toward_light;
  assign wr_ent.lit = head.cmd.lit_gain;
  assign wr_ent.dark = head.cmd.dark_gain;
  assign wr_ent.r = head.cmd.red;
  assign wr_ent.g = head.cmd.green;
  assign wr_ent.b = head.cmd.blue;
  assign wr_ent.amb_flag = head.cmd.flag_or_alpha[0];

  always_ff @(posedge clk) begin
    if (pop && head.valid && head.cmd.command == vvls_pkg::CMD_WRITE
        && int'(head.cmd.slot_or_count) < LIGHT_SLOTS) begin
      mem[IDXW'(head.cmd.slot_or_count)] <= wr_ent;
    end
    rd <= mem[idx[IDXW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head.valid && head.cmd.command == vvls_pkg::CMD_SHADE) begin
          state_next = (n_next == '0) ? S_FIN : S_RD;
        end
      end
      S_RD:   state_next = S_DOT;
      S_DOT:  state_next = S_SUM;
      S_SUM:  state_next = S_GAIN;
      S_GAIN: state_next = S_COL;
      S_COL:  state_next = S_ADD;
      S_ADD:  state_next = (idx + 1'b1 == n) ? S_FIN : S_RD;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign amb[0] = cur.red;
  assign amb[1] = cur.green;
  assign amb[2] = cur.blue;

  always_comb begin
    logic signed [59:0] base;
    logic signed [59:0] v;
    logic [60:0]        m;
    for (int c = 0; c < 3; c++) begin
      base = signed'({7'd0, amb[c], 40'd0});
      base = (s0[c] > base) ? s0[c] : base;
      v = base + s1[c];
      if (v < 0) v = '0;
      if (v > (60'sd1 <<< 52)) v = 60'sd1 <<< 52;
      m = ({1'b0, v} << 8) - {1'b0, v};
      byte_v[c] = m[59:52];
    end
  end

  always_comb begin
    if (sg > (49'sd1 <<< 40)) sc = 42'sd1 <<< 40;
    else if (sg < -(49'sd1 <<< 40)) sc = -(42'sd1 <<< 40);
    else sc = 42'(sg);
  end

  assign alpha_w = ({8'd0, cur.flag_or_alpha} << 8) - {8'd0, cur.flag_or_alpha};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= head.cmd;
        n <= n_next;
        idx <= '0;
        for (int c = 0; c < 3; c++) begin
          s0[c] <= '0;
          s1[c] <= '0;
        end
      end
      S_DOT: begin
        px <= rd.dx * cur.vec_x;
        py <= rd.dy * cur.vec_y;
        pz <= rd.dz * cur.vec_z;
      end
      S_SUM: s <= 34'(px) + 34'(py) + 34'(pz) + (34'(rd.off) <<< 16);
      S_GAIN: sg <= (s > 0) ? s * rd.lit : s * rd.dark;
      S_COL: begin
        cr <= sc * signed'({1'b0, rd.r});
        cg <= sc * signed'({1'b0, rd.g});
        cb <= sc * signed'({1'b0, rd.b});
      end
      S_ADD: begin
        idx <= idx + 1'b1;
        if (rd.amb_flag) begin
          s0[0] <= s0[0] + 60'(cr);
          s0[1] <= s0[1] + 60'(cg);
          s0[2] <= s0[2] + 60'(cb);
        end else begin
          s1[0] <= s1[0] + 60'(cr);
          s1[1] <= s1[1] + 60'(cg);
          s1[2] <= s1[2] + 60'(cb);
        end
      end
      S_FIN: begin
        out_red <= byte_v[0];
        out_green <= byte_v[1];
        out_blue <= byte_v[2];
        out_alpha <= (alpha_w[20:12] > 9'd255) ? 8'd255 : alpha_w[19:12];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_FIN);
    end
  end
endmodule

// ===== rtl/vertex_vector_light_shader_unit.sv =====
// top level of the per-vertex directional light shader
// depends on vvls_pkg, vvls_front, vvls_back
//
// requests enter on start while busy is low: command 0 stores a light
// in a slot, command 1 shades one vertex. a two-entry queue sits ahead
// of the shading sequencer, so busy rises only when both entries hold.
// max_lights is written on cfg_valid/cfg_ready (ready always high); the user
// must write it only while the unit is idle, which the unit does not enforce.
// a light write is taken in the idle state and gives no result.
// a shade is dequeued in the idle state, then runs the read, dot, sum,
// gain, colour and add states once per applied light, one shared dot, gain
// and colour multiply pass per light, then the finish state.
// each shade result shows on the out_ ports for one cycle with done
// high; the receiver cannot stall it.
// reset empties the queue, idles the sequencer and sets max_lights to 5;
// the light table is undefined until written.
module vertex_vector_light_shader_unit #(
  parameter int LIGHT_SLOTS = vvls_pkg::LIGHT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [4:0]         slot_or_count,
  input  logic signed [15:0] vec_x,
  input  logic signed [15:0] vec_y,
  input  logic signed [15:0] vec_z,
  input  logic signed [15:0] shift_toward_light,
  input  logic signed [15:0] lit_gain,
  input  logic signed [15:0] dark_gain,
  input  logic [12:0]        red,
  input  logic [12:0]        green,
  input  logic [12:0]        blue,
  input  logic [12:0]        flag_or_alpha,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output logic               done,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha
);
  vvls_pkg::cmd_t  req;
  vvls_pkg::head_t head;
  logic            pop;
  logic [3:0]      max_lights;

  assign cfg_ready = 1'b1;
  assign req.command = command;
  assign req.slot_or_count = slot_or_count;
  assign req.vec_x = vec_x;
  assign req.vec_y = vec_y;
  assign req.vec_z = vec_z;
  assign req.shift_toward_light = shift_toward_light;
  assign req.lit_gain = lit_gain;
  assign req.dark_gain = dark_gain;
  assign req.red = red;
  assign req.green = green;
  assign req.blue = blue;
  assign req.flag_or_alpha = flag_or_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lights <= 4'(vvls_pkg::MAX_LIGHTS_RST);
    end else if (cfg_valid && cfg_ready) begin
      max_lights <= cfg_data;
    end
  end

  vvls_front u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .head (head),
    .pop  (pop)
  );

  vvls_back #(.LIGHT_SLOTS(LIGHT_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_lights(max_lights),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );
endmodule

// ===== rtl/vvls_checker.sv =====
// port-level checks for the light shader unit, bound to the top level
// depends on vertex_vector_light_shader_unit_assert.svh
`include "vertex_vector_light_shader_unit_assert.svh"
module vvls_port_props (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  `VVLS_ASSERT_NEXT_ALWAYS(a_rst_no_done, clk, rst, !done)
  `VVLS_ASSERT_NEXT_ALWAYS(a_rst_not_busy, clk, rst, !busy)
  `VVLS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `VVLS_ASSERT_NEXT(a_idle_free, clk, rst, !busy && !start, !busy)
endmodule

bind vertex_vector_light_shader_unit vvls_port_props u_vvls_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// ===== bench/vvls_checker.sv =====
// result checker for the light shader unit: watches requests, config writes and results,
// predicts each shade from its own copy of the light table and compares field by field
// depends on vvls_pkg
`timescale 1ns / 100ps
module vvls_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  vvls_pkg::cmd_t  req,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [3:0]      cfg_data,
  input  logic            done,
  input  logic [7:0]      out_red,
  input  logic [7:0]      out_green,
  input  logic [7:0]      out_blue,
  input  logic [7:0]      out_alpha,
  output int              fail_count,
  output int              pending,
  output int              shades_seen,
  output int              writes_seen
);
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  vvls_pkg::light_t lights [vvls_pkg::LIGHT_SLOTS_DEF];
  logic [3:0]       light_limit;
  pixel_t           pixel_q [$];

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [7:0] channel_byte(longint v);
    longint t;
    t = v;
    if (t < 0) t = 0;
    if (t > (longint'(1) << 52)) t = longint'(1) << 52;
    t = (t * 255) >>> 52;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  function automatic pixel_t shade_pixel(vvls_pkg::cmd_t r);
    pixel_t     p;
    longint     s;
    longint     lim;
    longint     acc [2][3];
    longint     base;
    logic [12:0] amb [3];
    logic [12:0] col [3];
    int         n;
    int         k;
    int         a;
    amb = '{r.red, r.green, r.blue};
    lim = longint'(1) << 40;
    for (int c = 0; c < 3; c++) begin
      acc[0][c] = 0;
      acc[1][c] = 0;
    end
    n = r.slot_or_count;
    if (n > vvls_pkg::LIGHT_SLOTS_DEF) n = vvls_pkg::LIGHT_SLOTS_DEF;
    if (n > light_limit) n = light_limit;
    for (int i = 0; i < n; i++) begin
      s = longint'(lights[i].dx) * longint'(r.vec_x) + longint'(lights[i].dy) * longint'(r.vec_y)
        + longint'(lights[i].dz) * longint'(r.vec_z) + longint'(lights[i].off) * 65536;
      k = lights[i].amb_flag ? 0 : 1;
      if (s > 0) s = s * longint'(lights[i].lit);
      else s = s * longint'(lights[i].dark);
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      col = '{lights[i].r, lights[i].g, lights[i].b};
      for (int c = 0; c < 3; c++) acc[k][c] += s * longint'(col[c]);
    end
    for (int c = 0; c < 3; c++) begin
      base = (longint'(amb[c]) << 40);
      if (acc[0][c] > base) base = acc[0][c];
      case (c)
        0: p.r = channel_byte(base + acc[1][c]);
        1: p.g = channel_byte(base + acc[1][c]);
        default: p.b = channel_byte(base + acc[1][c]);
      endcase
    end
    a = (int'(r.flag_or_alpha) * 255) >> 12;
    p.a = (a > 255) ? 8'd255 : a[7:0];
    return p;
  endfunction

  initial begin
    fail_count = 0;
    shades_seen = 0;
    writes_seen = 0;
    light_limit = 4'(vvls_pkg::MAX_LIGHTS_RST);
  end

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      light_limit = 4'(vvls_pkg::MAX_LIGHTS_RST);
      pixel_q.delete();
    end else begin
      if (done) begin
        if (pixel_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pixel_q.pop_front();
          shades_seen++;
          if (out_red !== want.r) report("out_red", out_red, want.r);
          if (out_green !== want.g) report("out_green", out_green, want.g);
          if (out_blue !== want.b) report("out_blue", out_blue, want.b);
          if (out_alpha !== want.a) report("out_alpha", out_alpha, want.a);
        end
      end
      if (cfg_valid && cfg_ready) light_limit = cfg_data;
      if (start && !busy) begin
        if (req.command == vvls_pkg::CMD_SHADE) begin
          pixel_q.push_back(shade_pixel(req));
        end else begin
          writes_seen++;
          if (req.slot_or_count < vvls_pkg::LIGHT_SLOTS_DEF)
            lights[req.slot_or_count[3:0]] = '{req.vec_x, req.vec_y, req.vec_z,
              req.shift_toward_light, req.lit_gain, req.dark_gain,
              req.red, req.green, req.blue, req.flag_or_alpha[0]};
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// top of the light shader unit bench: clock, reset, request and config stimulus
// depends on vvls_pkg, vvls_checker and the unit under test
`timescale 1ns / 100ps
module tb_top;
  localparam int CYCLE_LIMIT = 2000000;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  vvls_pkg::cmd_t req;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [3:0]     cfg_data;
  logic           done;
  logic [7:0]     out_red, out_green, out_blue, out_alpha;
  int             fail_count, pending, shades_seen, writes_seen;
  int             cycles;
  bit             gaps_on;

  vertex_vector_light_shader_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(req.command), .slot_or_count(req.slot_or_count),
    .vec_x(req.vec_x), .vec_y(req.vec_y), .vec_z(req.vec_z),
    .shift_toward_light(req.shift_toward_light), .lit_gain(req.lit_gain),
    .dark_gain(req.dark_gain), .red(req.red), .green(req.green), .blue(req.blue),
    .flag_or_alpha(req.flag_or_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  vvls_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .fail_count(fail_count), .pending(pending),
    .shades_seen(shades_seen), .writes_seen(writes_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(vvls_pkg::cmd_t c);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_q(int span);
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic vvls_pkg::cmd_t rand_request();
    vvls_pkg::cmd_t c;
    c.command = ($urandom_range(0, 9) < 3) ? vvls_pkg::CMD_WRITE : vvls_pkg::CMD_SHADE;
    c.slot_or_count = (c.command == vvls_pkg::CMD_WRITE || $urandom_range(0, 4) == 0)
                      ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
    c.vec_x = rand_q(16384);
    c.vec_y = rand_q(16384);
    c.vec_z = rand_q(16384);
    c.shift_toward_light = rand_q(4096);
    c.lit_gain = rand_q(8192);
    c.dark_gain = rand_q(8192);
    c.red = 13'($urandom_range(0, 8191));
    c.green = 13'($urandom_range(0, 8191));
    c.blue = 13'($urandom_range(0, 8191));
    c.flag_or_alpha = 13'($urandom_range(0, 8191));
    return c;
  endfunction

  function automatic vvls_pkg::cmd_t make_light(int slot, logic signed [15:0] d,
                                                logic signed [15:0] g, logic [12:0] col,
                                                logic flag);
    vvls_pkg::cmd_t c;
    c = '{vvls_pkg::CMD_WRITE, 5'(slot), d, -d, d, g, g, -g, col, col, col, {12'd0, flag}};
    return c;
  endfunction

  function automatic vvls_pkg::cmd_t make_shade(int cnt, logic signed [15:0] nv,
                                                logic [12:0] amb, logic [12:0] alpha);
    vvls_pkg::cmd_t c;
    c = '{vvls_pkg::CMD_SHADE, 5'(cnt), nv, nv, -nv, 16'd0, 16'd0, 16'd0,
          amb, amb, amb, alpha};
    return c;
  endfunction

  initial begin
    logic [3:0] limits [6];
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cycles = 0;
    gaps_on = 1'b1;
    limits = '{4'd0, 4'd15, 4'd11, 4'd1, 4'd7, 4'd3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill every slot before any shade, extremes at the ends of the table
    send(make_light(0, 16'sh7fff, 16'sh7fff, 13'h1fff, 1'b1));
    send(make_light(15, 16'sh8000, 16'sh8000, 13'h1fff, 1'b0));
    for (int i = 1; i < 15; i++)
      send(make_light(i, 16'sh2000 - 16'(i * 1100), 16'(i * 600), 13'(i * 500), i[0]));
    // slot out of range is ignored
    send(make_light(31, 16'sh7fff, 16'sh7fff, 13'h0, 1'b0));
    send(make_shade(0, 16'sh4000, 13'h0800, 13'h0));
    send(make_shade(16, 16'sh7fff, 13'h1fff, 13'h1fff));
    send(make_shade(31, 16'sh8000, 13'h0, 13'h1000));
    send(make_shade(5, 16'sh0, 13'h0, 13'h0fff));
    send(make_shade(3, 16'sh8000, 13'h0400, 13'h0800));
    send(make_shade(16, 16'sh4000, 13'h0, 13'h1fff));
    set_limit(4'd15);
    send(make_shade(16, 16'sh7fff, 13'h0, 13'h0));
    send(make_shade(16, 16'sh8000, 13'h0100, 13'h0010));

    for (int p = 0; p < 6; p++) begin
      set_limit(limits[p]);
      for (int i = 0; i < 295; i++) begin
        if (i % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
        if (i == 150 && p == 2) drain();
        send(rand_request());
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d light writes and %0d shades over max_lights 0, 1, 3, 5, 7, 11, 15",
             writes_seen, shades_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== vertex_vector_light_shader_unit.f =====
+incdir+rtl
rtl/vvls_pkg.sv
rtl/vvls_front.sv
rtl/vvls_back.sv
rtl/vertex_vector_light_shader_unit.sv
rtl/vvls_checker.sv
bench/vvls_checker.sv
bench/tb_top.sv
